// ===== hdl/rc4s_pkg.sv =====
// Package for the RC4 stream cipher: configuration types, reset values and
// register indexes. It depends on nothing else.
package rc4s_pkg;

    localparam int ADDR_W    = 5;
    localparam int KEY_LEN_W = 5;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [63:0]          KEY_LOW_RST  = 64'h6F62613A3A647473;
    localparam logic [63:0]          KEY_HIGH_RST = 64'h0000003B29287472;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST  = 5'd13;

    typedef struct packed {
        logic [63:0]          key_low;
        logic [63:0]          key_high;
        logic [KEY_LEN_W-1:0] key_len;
    } t_key_cfg;

endpackage

// ===== hdl/rc4s_if.sv =====
// Handshake interfaces for the RC4 stream cipher's input and result channels.
// They depend on nothing else.
interface rc4s_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_in;

    modport source (output valid, output mode, output data_in, input ready);
    modport sink (input valid, input mode, input data_in, output ready);
endinterface

interface rc4s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

// ===== hdl/rc4s_core.sv =====
// Permutation memory, key schedule and keystream sequencer of the RC4 cipher.
// It depends on rc4s_pkg and the interfaces in rc4s_if.
module rc4s_core #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4s_pkg::t_key_cfg i_cfg,
    rc4s_in_if.sink           i_in,
    rc4s_out_if.source        o_out
);

    localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [rc4s_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4s_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD_I = 3'd2;
    localparam logic [2:0] ST_RD_J = 3'd3;
    localparam logic [2:0] ST_WR_I = 3'd4;
    localparam logic [2:0] ST_WR_J = 3'd5;

    logic [7:0] r_sbox [256];

    logic [2:0]           r_state, n_state;
    logic [7:0]           r_i, n_i;
    logic [7:0]           r_j, n_j;
    logic [KEY_IDX_W-1:0] r_k, n_k;
    logic                 r_mode, n_mode;
    logic                 r_out_valid, n_out_valid;

    logic [7:0] r_rda, r_rdb;
    logic [7:0] r_a, r_b, r_t, r_din, r_out_data;

    logic                          w_we;
    logic [7:0]                    w_waddr, w_wdata, w_addra, w_addrb;
    logic [7:0]                    w_j_next, w_key_term, w_ks;
    logic [rc4s_pkg::KEY_LEN_W-1:0] w_len, w_k_inc;
    logic [127:0]                  w_key_all;
    logic [3:0]                    w_key_sel;
    logic                          w_out_free, w_done;

    assign w_len = (i_cfg.key_len == '0 || i_cfg.key_len > MAX_LEN) ? MAX_LEN : i_cfg.key_len;
    assign w_k_inc = rc4s_pkg::KEY_LEN_W'(r_k) + 1'b1;
    assign w_key_all = {i_cfg.key_high, i_cfg.key_low};
    assign w_key_sel = 4'(r_k);
    assign w_key_term = r_mode ? 8'd0 : w_key_all[{w_key_sel, 3'b000} +: 8];
    assign w_j_next = r_j + r_rda + w_key_term;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_done = (r_state == ST_WR_J) && r_mode && w_out_free;

    // The keystream entry is read before the swap is written, so an address
    // that hits i or j takes the swapped value; j wins when i equals j.
    assign w_ks = (r_t == r_j) ? r_a : ((r_t == r_i) ? r_b : r_rda);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = r_i;
        w_addra = r_i;
        w_addrb = w_j_next;
        case (r_state)
            ST_FILL: begin
                w_we = 1'b1;
            end
            ST_WR_I: begin
                w_we    = 1'b1;
                w_wdata = r_rdb;
                w_addra = r_a + r_rdb;
            end
            ST_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_a;
                w_addra = r_t;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sbox[w_waddr] <= w_wdata;
        end
        r_rda <= r_sbox[w_addra];
        r_rdb <= r_sbox[w_addrb];
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_mode = i_in.mode;
                    if (i_in.mode) begin
                        n_i     = r_i + 8'd1;
                        n_state = ST_RD_I;
                    end else begin
                        n_i     = 8'd0;
                        n_j     = 8'd0;
                        n_k     = '0;
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                n_i = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_j = w_j_next;
                if (!r_mode) begin
                    n_k = (w_k_inc >= w_len) ? '0 : KEY_IDX_W'(w_k_inc);
                end
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                if (r_mode) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if (r_i == 8'hFF) begin
                    n_i     = 8'd0;
                    n_j     = 8'd0;
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + 8'd1;
                    n_state = ST_RD_I;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_k         <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_din <= i_in.data_in;
        end
        if (r_state == ST_RD_J) begin
            r_a <= r_rda;
        end
        if (r_state == ST_WR_I) begin
            r_b <= r_rdb;
            r_t <= w_addra;
        end
        if (w_done) begin
            r_out_data <= r_din ^ w_ks;
        end
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;

endmodule

// ===== hdl/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher: the APB register file and the core.
// It depends on rc4s_pkg, the interfaces in rc4s_if and rc4s_core.
//
// Usage. A transaction on the input channel carries mode and data_in. A mode 0
// transaction runs the key schedule with the key held in the registers and
// clears both generator indices; it gives no result. A mode 1 transaction
// ciphers one byte and gives one result transaction with data_out.
// A mode 1 byte is accepted in idle and passes through the read-i, read-j,
// write-i and write-j states; its result is registered on leaving write-j,
// and the next byte is taken only back in idle. Each swap needs two writes,
// as the permutation memory has a single write port. A key schedule fills
// all 256 entries, then runs 256 swaps through the same four states.
// Registers: key_bytes_low at 0x00, key_bytes_high at 0x08 and key_length
// at 0x10; write them only while the block is idle.
// Reset clears the indices, the state and the result valid flag; the
// permutation holds nothing useful until a key schedule has run. While the
// receiver stalls, the result holds and a further byte may be accepted, but
// it is not completed until the held result has been taken.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rc4s_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    rc4s_in_if.sink                     i_in,
    rc4s_out_if.source                  o_out
);

    rc4s_pkg::t_key_cfg r_cfg;
    logic [1:0]         w_reg_idx;
    logic               w_wr;

    assign w_reg_idx = paddr[4:3];
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_low  <= rc4s_pkg::KEY_LOW_RST;
            r_cfg.key_high <= rc4s_pkg::KEY_HIGH_RST;
            r_cfg.key_len  <= rc4s_pkg::KEY_LEN_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                rc4s_pkg::REG_KEY_LOW:  r_cfg.key_low  <= pwdata;
                rc4s_pkg::REG_KEY_HIGH: r_cfg.key_high <= pwdata;
                rc4s_pkg::REG_KEY_LEN:  r_cfg.key_len  <= pwdata[rc4s_pkg::KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            rc4s_pkg::REG_KEY_LOW:  prdata = r_cfg.key_low;
            rc4s_pkg::REG_KEY_HIGH: prdata = r_cfg.key_high;
            rc4s_pkg::REG_KEY_LEN:  prdata = {{(64 - rc4s_pkg::KEY_LEN_W){1'b0}}, r_cfg.key_len};
            default:                prdata = 64'd0;
        endcase
    end

    rc4s_core #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .o_out  (o_out)
    );

endmodule

// ===== hdl/rc4s_checker.sv =====
// Port-level checks for the RC4 stream cipher, attached to the top level by
// the bind statement at the end. It depends only on the top level's ports.
module rc4s_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted while a byte is in progress");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(w_in_acc, 1) && !$past(w_in_acc, 2))
        else $error("result appeared too soon after an input transaction");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind rc4_stream_cipher rc4s_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data_out)
);
